// ===== src/conv3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3_pkg
// Shared types, constants and the per-channel kernel datapath for the
// 3x3 convolution core.
// ----------------------------------------------------------------------------
package conv3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W    = 12;
    localparam int PIX_W       = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int OUT_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_SELECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

    typedef enum logic [1:0] {
        KERNEL_CONTRAST = 2'd0,
        KERNEL_BLUR     = 2'd1,
        KERNEL_RELIEF   = 2'd2,
        KERNEL_EDGE     = 2'd3
    } kernel_t;

    // win holds the nine window samples of one channel, tap 0 in the low byte.
    // Tap order: row-major, top-left first.
    function automatic logic [7:0] filter_px(kernel_t sel, logic [71:0] win);
        logic signed [13:0] p [9];
        logic signed [13:0] sum;
        logic [7:0]         res;
        for (int i = 0; i < 9; i++) begin
            p[i] = signed'({6'd0, win[i*8 +: 8]});
        end
        unique case (sel)
            KERNEL_CONTRAST: begin
                sum = (p[4] <<< 2) + p[4] - p[1] - p[3] - p[5] - p[7];
            end
            KERNEL_BLUR: begin
                // taps scaled by 16; sum is never negative, so the shift floors
                sum = (p[0] + p[2] + p[6] + p[8] + ((p[1] + p[3] + p[5] + p[7]) <<< 1)
                       + (p[4] <<< 2)) >>> 4;
            end
            KERNEL_RELIEF: begin
                sum = p[4] + p[5] + p[7] + (p[8] <<< 1) - (p[0] <<< 1) - p[1] - p[3];
            end
            KERNEL_EDGE: begin
                sum = (p[4] <<< 3) - p[0] - p[1] - p[2] - p[3] - p[5] - p[6] - p[7]
                      - p[8];
            end
            default: begin
                sum = '0;
            end
        endcase
        if (sum < 0) begin
            res = 8'd0;
        end else if (sum > 14'sd255) begin
            res = 8'd255;
        end else begin
            res = sum[7:0];
        end
        return res;
    endfunction

endpackage

// ===== src/convolution_3x3_kernel_select_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convolution_3x3_kernel_select_core
// Streaming 3x3 RGB image filter with a register-selected kernel.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per cycle in raster order unless stalled and emits one
// filtered result per interior pixel, via the stage 1 and output registers,
// after the pixel that completes its 3x3 window (the pixel at column x+1,
// row y+1 completes the window of (x, y)). Sustained rate is one pixel per
// clock: the two previous rows live in one 48-bit wide line memory that is
// read at accept and written back as the pixel leaves stage 1; a same-column
// read in the write-back cycle (narrow images) is forwarded. Border pixels
// produce no output transfer. Writing image_width or image_height restarts
// the frame; change registers only while idle. The line memory is not
// cleared after reset; its stale contents never reach an output.
module convolution_3x3_kernel_select_core
    import conv3_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // filtered output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // out_red[7:0], out_green[15:8],
                                              // out_blue[23:16], column[33:24],
                                              // row[45:34], zero[47:46]
    output logic                   m_tlast    // frame_done
);

    // configuration
    kernel_t              kernel_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [WIDTH_W-1:0]   w_eff;
    logic [HEIGHT_W-1:0]  h_eff;
    logic                 cfg_fire;

    // raster counters
    logic [ADDR_W-1:0]    col_reg;
    logic [HEIGHT_W-1:0]  row_reg;
    logic                 last_col;
    logic                 last_row;

    // line memory: {row y-2, row y-1} per column
    logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]   rd_data_reg;
    logic [2*PIX_W-1:0]   fwd_data_reg;
    logic                 fwd_reg;
    logic [2*PIX_W-1:0]   line_eff;
    logic [2*PIX_W-1:0]   wr_data;

    // stage 1
    logic                 s1_valid_reg;
    logic [PIX_W-1:0]     s1_pix_reg;
    logic [ADDR_W-1:0]    s1_x_reg;
    logic [HEIGHT_W-1:0]  s1_y_reg;
    logic                 s1_last_col_reg;
    logic                 s1_last_row_reg;
    logic                 s1_emit;
    logic                 s1_fire;
    logic                 s_fire;

    logic [PIX_W-1:0]     win_reg [6];
    logic [PIX_W-1:0]     win [9];
    logic [PIX_W-1:0]     top_px;
    logic [PIX_W-1:0]     mid_px;
    logic [71:0]          win_ch [3];
    logic [7:0]           res_ch [3];

    // output register
    logic                 m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg <= KERNEL_CONTRAST;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_KERNEL_SELECT: kernel_reg <= kernel_t'(cfg_data[1:0]);
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (width_reg > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    // ---------------------------------------------------------------- handshake
    assign s1_emit  = (s1_x_reg >= ADDR_W'(2)) && (s1_y_reg >= HEIGHT_W'(2));
    assign s1_fire  = s1_valid_reg && (!s1_emit || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid & s_tready;

    // ---------------------------------------------------------------- counters
    assign last_col = ({1'b0, col_reg} + WIDTH_W'(1)) == w_eff;
    assign last_row = ({1'b0, row_reg} + (HEIGHT_W + 1)'(1)) == {1'b0, h_eff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_fire && (cfg_index == CFG_IMAGE_WIDTH ||
                                  cfg_index == CFG_IMAGE_HEIGHT)) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_fire) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + HEIGHT_W'(1);
            end else begin
                col_reg <= col_reg + ADDR_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------- line memory
    assign line_eff = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign top_px   = line_eff[2*PIX_W-1:PIX_W];
    assign mid_px   = line_eff[PIX_W-1:0];
    assign wr_data  = {mid_px, s1_pix_reg};

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (s1_fire) begin
            line_mem[s1_x_reg] <= wr_data;
        end
    end

    // same column read while its previous write is still going in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (s_fire) begin
            fwd_reg <= s1_fire && (s1_x_reg == col_reg);
        end else if (s1_fire) begin
            fwd_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fwd_data_reg <= wr_data;
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_pix_reg      <= s_tdata;
            s1_x_reg        <= col_reg;
            s1_y_reg        <= row_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_fire) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top_px;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid_px;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_pix_reg;
        end
    end

    always_comb begin
        win[0] = win_reg[0];
        win[1] = win_reg[1];
        win[2] = top_px;
        win[3] = win_reg[2];
        win[4] = win_reg[3];
        win[5] = mid_px;
        win[6] = win_reg[4];
        win[7] = win_reg[5];
        win[8] = s1_pix_reg;
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 9; i++) begin
                win_ch[c][i*8 +: 8] = win[i][c*8 +: 8];
            end
            res_ch[c] = filter_px(kernel_reg, win_ch[c]);
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_emit) begin
            m_data_reg <= {2'b00,
                           s1_y_reg - HEIGHT_W'(1),
                           s1_x_reg - ADDR_W'(1),
                           res_ch[2], res_ch[1], res_ch[0]};
            m_last_reg <= s1_last_col_reg & s1_last_row_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------- checks
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < w_eff)
        else $error("column counter outside image width");

    a_fwd_live: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> s1_valid_reg)
        else $error("forward flag set without an item in stage 1");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_x_reg)
                                        && $stable(s1_pix_reg)))
        else $error("stalled stage 1 item changed");

endmodule
